/* src/gda_pkg.sv */
// Shared types, constants and calendar helper functions for the Gregorian
// date arithmetic block. No dependencies.
package gda_pkg;

  localparam int DAY_COUNT_BITS_DEF = 23;
  localparam int DAY_BITS = 22;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [21:0] DAYS_MIN = 22'd146037;
  localparam logic [21:0] DAYS_MAX = 22'd3798461;
  localparam logic [17:0] ERA_DAYS = 18'd146097;

  localparam logic [14:0] M100   = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
  localparam logic [22:0] M_ERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [18:0] M1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] M36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] M365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] M153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  typedef struct packed {
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [14:0] yy;
    logic [7:0]  qy;
    logic [7:0]  qyy;
    logic [8:0]  doy;
  } date_pre_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] status;
    logic       a_first;
    logic       equal;
  } side_t;

  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'(M100);
    return 8'(p >> 21);
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] l;
    case (m)
      4'd2:                      l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        l = 5'd31;
      default:                   l = 5'd0;
    endcase
    return l;
  endfunction

  function automatic date_pre_t date_prep(input logic [13:0] y, input logic [3:0] m,
                                          input logic [4:0] d);
    date_pre_t p;
    logic [3:0] mp;
    p.y   = y;
    p.m   = m;
    p.d   = d;
    p.yy  = 15'(y) + 15'd400 - ((m <= 4'd2) ? 15'd1 : 15'd0);
    p.qy  = div100(15'(y));
    p.qyy = div100(p.yy);
    mp    = (m > 4'd2) ? m - 4'd3 : m + 4'd9;
    p.doy = month_start(mp) + 9'(d) - 9'd1;
    return p;
  endfunction

  function automatic logic date_ok(input date_pre_t p);
    logic [14:0] h;
    logic        leap;
    logic [4:0]  len;
    h    = 15'(p.qy) * 15'd100;
    leap = ((p.y[1:0] == 2'd0) && (15'(p.y) != h)) ||
           ((15'(p.y) == h) && (p.qy[1:0] == 2'd0));
    len  = month_len(p.m) + (((p.m == 4'd2) && leap) ? 5'd1 : 5'd0);
    return (p.y <= YEAR_MAX) && (p.m >= 4'd1) && (p.m <= 4'd12) &&
           (p.d != 5'd0) && (p.d <= len);
  endfunction

  function automatic logic [21:0] date_days(input date_pre_t p);
    logic [22:0] s;
    s = 23'(p.yy) * 23'd365 + 23'(p.yy >> 2) - 23'(p.qyy) + 23'(p.qyy >> 2) + 23'(p.doy);
    return 22'(s);
  endfunction

endpackage

/* src/gda_if.sv */
// Request and result channel interfaces of the date arithmetic block.
// Depends on nothing; the day count width is a parameter.
interface gda_in_if #(parameter int DAY_COUNT_BITS = 23);
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [13:0]                      year_a;
  logic [3:0]                       month_a;
  logic [4:0]                       day_a;
  logic [13:0]                      year_b;
  logic [3:0]                       month_b;
  logic [4:0]                       day_b;
  logic signed [DAY_COUNT_BITS-1:0] offset;

  modport source (output valid, mode, year_a, month_a, day_a, year_b, month_b, day_b,
                  offset, input ready);
  modport sink (input valid, mode, year_a, month_a, day_a, year_b, month_b, day_b,
                offset, output ready);
endinterface

interface gda_out_if #(parameter int DAY_COUNT_BITS = 23);
  logic                             valid;
  logic                             ready;
  logic [13:0]                      res_year;
  logic [3:0]                       res_month;
  logic [4:0]                       res_day;
  logic signed [DAY_COUNT_BITS-1:0] difference;
  logic                             a_before_b;
  logic                             a_equals_b;
  logic [1:0]                       status;

  modport source (output valid, res_year, res_month, res_day, difference, a_before_b,
                  a_equals_b, status, input ready);
  modport sink (input valid, res_year, res_month, res_day, difference, a_before_b,
                a_equals_b, status, output ready);
endinterface

/* src/gda_from_days.sv */
// Eight-stage pipeline that turns a day number back into year, month and day.
// Depends on gda_pkg; stages advance together on the shared enable.
module gda_from_days
  import gda_pkg::*;
#(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_vld,
  input  side_t                            in_side,
  input  logic signed [DAY_COUNT_BITS-1:0] in_diff,
  input  logic [DAY_BITS-1:0]              in_z,
  output logic                             out_vld,
  output side_t                            out_side,
  output logic signed [DAY_COUNT_BITS-1:0] out_diff,
  output logic [13:0]                      out_year,
  output logic [3:0]                       out_month,
  output logic [4:0]                       out_day
);

  localparam int NSTG = 8;

  logic                             vld_r  [NSTG];
  side_t                            side_r [NSTG];
  logic signed [DAY_COUNT_BITS-1:0] diff_r [NSTG];

  logic [DAY_BITS-1:0] f1_z_r;
  logic [4:0]          f1_era_r, f2_era_r, f3_era_r, f4_era_r, f5_era_r, f6_era_r, f7_era_r;
  logic [17:0]         f2_doe_r, f3_doe_r, f4_doe_r, f5_doe_r;
  logic [6:0]          f3_q1460_r;
  logic [2:0]          f3_q36524_r;
  logic                f3_end_r;
  logic [8:0]          f4_yoe_r, f5_yoe_r, f6_yoe_r, f7_yoe_r;
  logic [17:0]         f5_t_r;
  logic [8:0]          f6_doy_r, f7_doy_r;
  logic [10:0]         f6_x_r;
  logic [3:0]          f7_mp_r;
  logic [13:0]         year_r;
  logic [3:0]          month_r;
  logic [4:0]          day_r;

  logic [44:0] era_p;
  logic [17:0] doe_nxt;
  logic [36:0] q1460_p, q36524_p, yoe_p;
  logic [17:0] num;
  logic [17:0] t_nxt;
  logic [8:0]  doy_nxt;
  logic [22:0] mp_p;
  logic [3:0]  mm;
  logic [14:0] yr;
  logic        keep;

  always_comb begin
    era_p    = 45'(in_z) * 45'(M_ERA);
    doe_nxt  = 18'(22'(f1_z_r) - 22'(f1_era_r) * 22'(ERA_DAYS));
    q1460_p  = 37'(f2_doe_r) * 37'(M1460);
    q36524_p = 37'(f2_doe_r) * 37'(M36524);
    num      = f3_doe_r - 18'(f3_q1460_r) + 18'(f3_q36524_r) - 18'(f3_end_r);
    yoe_p    = 37'(num) * 37'(M365);
    t_nxt    = 18'(f4_yoe_r) * 18'd365 + 18'(f4_yoe_r >> 2) - 18'(div100(15'(f4_yoe_r)));
    doy_nxt  = 9'(f5_doe_r - f5_t_r);
    mp_p     = 23'(f6_x_r) * 23'(M153);
    mm       = (f7_mp_r < 4'd10) ? f7_mp_r + 4'd3 : f7_mp_r - 4'd9;
    yr       = 15'(f7_yoe_r) + 15'(f7_era_r) * 15'd400 + ((mm <= 4'd2) ? 15'd1 : 15'd0)
               - 15'd400;
    keep     = (side_r[6].status == ST_OK) && !side_r[6].mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < NSTG; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      diff_r[0] <= in_diff;
      for (int i = 1; i < NSTG; i++) begin
        side_r[i] <= side_r[i-1];
        diff_r[i] <= diff_r[i-1];
      end
      f1_z_r      <= in_z;
      f1_era_r    <= 5'(era_p >> 40);
      f2_era_r    <= f1_era_r;
      f2_doe_r    <= doe_nxt;
      f3_era_r    <= f2_era_r;
      f3_doe_r    <= f2_doe_r;
      f3_q1460_r  <= 7'(q1460_p >> 29);
      f3_q36524_r <= 3'(q36524_p >> 34);
      f3_end_r    <= (f2_doe_r == ERA_DAYS - 18'd1);
      f4_era_r    <= f3_era_r;
      f4_doe_r    <= f3_doe_r;
      f4_yoe_r    <= 9'(yoe_p >> 27);
      f5_era_r    <= f4_era_r;
      f5_doe_r    <= f4_doe_r;
      f5_yoe_r    <= f4_yoe_r;
      f5_t_r      <= t_nxt;
      f6_era_r    <= f5_era_r;
      f6_yoe_r    <= f5_yoe_r;
      f6_doy_r    <= doy_nxt;
      f6_x_r      <= 11'(doy_nxt) * 11'd5 + 11'd2;
      f7_era_r    <= f6_era_r;
      f7_yoe_r    <= f6_yoe_r;
      f7_doy_r    <= f6_doy_r;
      f7_mp_r     <= 4'(mp_p >> 19);
      year_r      <= keep ? 14'(yr) : 14'd0;
      month_r     <= keep ? mm : 4'd0;
      day_r       <= keep ? 5'(f7_doy_r - month_start(f7_mp_r) + 9'd1) : 5'd0;
    end
  end

  assign out_vld   = vld_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];
  assign out_diff  = diff_r[NSTG-1];
  assign out_year  = year_r;
  assign out_month = month_r;
  assign out_day   = day_r;

endmodule

/* src/gregorian_date_arithmetic.sv */
// Top level of the Gregorian date arithmetic block: date decode, day numbers,
// offset and difference stages, then the gda_from_days pipeline. Uses gda_pkg, gda_if.
//
//   channel | direction | contents
//   in_ch   | request   | mode, date A, date B, signed day offset
//   out_ch  | result    | result date, difference, compare flags, status
//
// One request is taken every cycle unless a stalled result holds the pipeline.
// The depth is set by the day-number conversion and its reciprocal multipliers.
// Reset clears all valid bits; no clearing pass is needed.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module gregorian_date_arithmetic
  import gda_pkg::*;
#(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  gda_in_if.sink    in_ch,
  gda_out_if.source out_ch
);

  localparam int NW = ((DAY_COUNT_BITS > 23) ? DAY_COUNT_BITS : 23) + 1;
  localparam logic signed [NW-1:0] DIFF_HI = NW'((64'sd1 <<< (DAY_COUNT_BITS - 1)) - 64'sd1);
  localparam logic signed [NW-1:0] DIFF_LO = -DIFF_HI - NW'(1);

  logic adv;

  logic                             s1_vld_r, s1_mode_r, s1_first_r, s1_equal_r;
  date_pre_t                        s1_a_r, s1_b_r;
  logic signed [DAY_COUNT_BITS-1:0] s1_off_r;

  logic                             s2_vld_r, s2_mode_r, s2_first_r, s2_equal_r;
  logic                             s2_va_r, s2_vb_r;
  logic [DAY_BITS-1:0]              s2_days_a_r, s2_days_b_r;
  logic signed [DAY_COUNT_BITS-1:0] s2_off_r;

  logic                             s3_vld_r;
  side_t                            s3_side_r;
  logic signed [DAY_COUNT_BITS-1:0] s3_diff_r;
  logic [DAY_BITS-1:0]              s3_z_r;

  logic signed [NW-1:0] n, dd, dsat;
  side_t                side_nxt;
  logic                 f_vld;
  side_t                f_side;

  always_comb begin
    n    = NW'(signed'({1'b0, s2_days_a_r})) + NW'(s2_off_r);
    dd   = NW'(signed'({1'b0, s2_days_a_r})) - NW'(signed'({1'b0, s2_days_b_r}));
    dsat = (dd > DIFF_HI) ? DIFF_HI : ((dd < DIFF_LO) ? DIFF_LO : dd);
    side_nxt.mode    = s2_mode_r;
    side_nxt.a_first = s2_first_r;
    side_nxt.equal   = s2_equal_r;
    if (!s2_mode_r) begin
      if (!s2_va_r) begin
        side_nxt.status = ST_INVALID;
      end else if (n < NW'(DAYS_MIN) || n > NW'(DAYS_MAX)) begin
        side_nxt.status = ST_RANGE;
      end else begin
        side_nxt.status = ST_OK;
      end
    end else begin
      side_nxt.status = (s2_va_r && s2_vb_r) ? ST_OK : ST_INVALID;
    end
  end

  assign adv = !f_vld || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r   <= in_ch.mode;
      s1_a_r      <= date_prep(in_ch.year_a, in_ch.month_a, in_ch.day_a);
      s1_b_r      <= date_prep(in_ch.year_b, in_ch.month_b, in_ch.day_b);
      s1_off_r    <= in_ch.offset;
      s1_equal_r  <= (in_ch.year_a == in_ch.year_b) && (in_ch.month_a == in_ch.month_b) &&
                     (in_ch.day_a == in_ch.day_b);
      s1_first_r  <= {in_ch.year_a, in_ch.month_a, in_ch.day_a} <
                     {in_ch.year_b, in_ch.month_b, in_ch.day_b};
      s2_mode_r   <= s1_mode_r;
      s2_first_r  <= s1_first_r;
      s2_equal_r  <= s1_equal_r;
      s2_off_r    <= s1_off_r;
      s2_va_r     <= date_ok(s1_a_r);
      s2_vb_r     <= date_ok(s1_b_r);
      s2_days_a_r <= date_days(s1_a_r);
      s2_days_b_r <= date_days(s1_b_r);
      s3_side_r   <= side_nxt;
      s3_diff_r   <= (s2_mode_r && side_nxt.status == ST_OK) ? DAY_COUNT_BITS'(dsat) : '0;
      s3_z_r      <= DAY_BITS'(n);
    end
  end

  gda_from_days #(.DAY_COUNT_BITS(DAY_COUNT_BITS)) u_from_days (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (s3_vld_r),
    .in_side   (s3_side_r),
    .in_diff   (s3_diff_r),
    .in_z      (s3_z_r),
    .out_vld   (f_vld),
    .out_side  (f_side),
    .out_diff  (out_ch.difference),
    .out_year  (out_ch.res_year),
    .out_month (out_ch.res_month),
    .out_day   (out_ch.res_day)
  );

  assign out_ch.valid      = f_vld;
  assign out_ch.a_before_b = f_side.a_first;
  assign out_ch.a_equals_b = f_side.equal;
  assign out_ch.status     = f_side.status;

  a_bad_no_date : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.res_year == 14'd0 && out_ch.res_month == 4'd0 && out_ch.res_day == 5'd0)
    else $error("result date not cleared on bad status");

  a_date_no_diff : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.res_month != 4'd0 |-> out_ch.difference == '0)
    else $error("difference set alongside a result date");

  a_cmp_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.a_before_b |-> !out_ch.a_equals_b)
    else $error("before and equal both set");

  a_stall_only : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("request stalled without a blocked result");

endmodule
